// File: src/emr_pkg.sv
// Package with shared types and constants for the Eller maze row generator.
`timescale 1ns / 1ps

package emr_pkg;

  localparam int MAX_CELLS = 32;
  localparam int IDX_W = 5;
  localparam int LABEL_W = 5;
  localparam int ROW_CELLS_DEFAULT = 32;

  typedef struct packed {
    logic [MAX_CELLS-2:0] join_bits;
    logic [MAX_CELLS-1:0] down_bits;
    logic                 first_row;
    logic                 final_row;
  } item_word_t;

  typedef struct packed {
    logic [MAX_CELLS-1:0] right_walls;
    logic [MAX_CELLS-1:0] bottom_walls;
    logic                 maze_done;
  } row_word_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_START,
    CMD_FORM,
    CMD_JOIN
  } lab_cmd_t;

  typedef struct packed {
    lab_cmd_t         cmd;
    logic [IDX_W-1:0] idx;
    logic             carried;
    logic             join_take;
  } lab_ctrl_t;

  typedef struct packed {
    logic                 differ;
    logic [MAX_CELLS-1:0] leader;
  } lab_stat_t;

endpackage

// File: src/eller_maze_row_generator.sv
// Top level of the Eller maze row generator.
// After an item word is taken, the row is formed in S_FORM, joined in S_JOIN and registered in S_DONE.
// Items are taken only in S_IDLE; the single label compare and merge unit
// forms the row one cell per cycle and then tries one join per cycle.
// Reset: every cell holds its own set label and no cell is carried down.
// A finished row waits in the output register while the next item word is accepted.
`timescale 1ns / 1ps

module eller_maze_row_generator #(
  parameter int ROW_CELLS = emr_pkg::ROW_CELLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  emr_pkg::item_word_t item,
  output logic                row_valid,
  input  logic                row_stall,
  output emr_pkg::row_word_t  row
);
  import emr_pkg::*;

  localparam int CELLS = (ROW_CELLS < 2) ? 2 : ((ROW_CELLS > MAX_CELLS) ? MAX_CELLS : ROW_CELLS);
  localparam logic [MAX_CELLS:0] ONE_WIDE = 1;
  localparam logic [MAX_CELLS-1:0] ROW_MASK = MAX_CELLS'((ONE_WIDE << CELLS) - 1);

  lab_ctrl_t ctrl;
  lab_stat_t stat;

  emr_seq #(
    .CELLS(CELLS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .row_valid(row_valid),
    .row_stall(row_stall),
    .row(row),
    .ctrl(ctrl),
    .stat(stat)
  );

  emr_label_unit u_label (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .stat(stat)
  );

  a_outside_row_clear: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> ((row.right_walls & ~ROW_MASK) == '0) && ((row.bottom_walls & ~ROW_MASK) == '0))
    else $error("Wall bits set outside the row.");

  a_last_cell_right_wall: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> row.right_walls[CELLS-1])
    else $error("Rightmost cell lacks its right wall.");

  a_final_row_closed: assert property (@(posedge clk) disable iff (rst)
    row_valid && row.maze_done |-> row.bottom_walls == ROW_MASK)
    else $error("Final row has a downward opening.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("Item accepted while the previous one is still in work.");

endmodule

// File: src/emr_label_unit.sv
// Set label store with the shared compare and merge unit for row formation and joins.
`timescale 1ns / 1ps

module emr_label_unit (
  input  logic              clk,
  input  logic              rst,
  input  emr_pkg::lab_ctrl_t ctrl,
  output emr_pkg::lab_stat_t stat
);
  import emr_pkg::*;

  logic [LABEL_W-1:0] labels [MAX_CELLS];
  logic [LABEL_W-1:0] first_of [MAX_CELLS];
  logic [MAX_CELLS-1:0] seen;
  logic [IDX_W-1:0] idx_right;
  logic [LABEL_W-1:0] lab_a;
  logic [LABEL_W-1:0] lab_b;
  logic [LABEL_W-1:0] keep;
  logic [LABEL_W-1:0] gone;
  logic do_merge;

  always_comb begin
    idx_right = ctrl.idx + IDX_W'(1);
    lab_a = labels[ctrl.idx];
    lab_b = labels[idx_right];
    keep = (lab_a < lab_b) ? lab_a : lab_b;
    gone = (lab_a < lab_b) ? lab_b : lab_a;
    do_merge = (ctrl.cmd == CMD_JOIN) && ctrl.join_take && (lab_a != lab_b);
    stat.differ = (lab_a != lab_b);
    for (int i = 0; i < MAX_CELLS; i++) begin
      stat.leader[i] = (labels[i] == LABEL_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CELLS; i++) begin
        labels[i] <= LABEL_W'(i);
      end
      seen <= '0;
    end else begin
      case (ctrl.cmd)
        CMD_START: begin
          seen <= '0;
        end
        CMD_FORM: begin
          if (ctrl.carried && seen[lab_a]) begin
            labels[ctrl.idx] <= first_of[lab_a];
          end else begin
            labels[ctrl.idx] <= ctrl.idx;
            if (ctrl.carried) begin
              seen[lab_a] <= 1'b1;
            end
          end
        end
        CMD_JOIN: begin
          if (do_merge) begin
            for (int i = 0; i < MAX_CELLS; i++) begin
              if (labels[i] == gone) begin
                labels[i] <= keep;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_FORM && ctrl.carried && !seen[lab_a]) begin
      first_of[lab_a] <= ctrl.idx;
    end
  end

endmodule

// File: src/emr_seq.sv
// Sequencer that steps the label unit over the row and builds the wall words.
`timescale 1ns / 1ps

module emr_seq #(
  parameter int CELLS = emr_pkg::ROW_CELLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  emr_pkg::item_word_t item,
  output logic                row_valid,
  input  logic                row_stall,
  output emr_pkg::row_word_t  row,
  output emr_pkg::lab_ctrl_t  ctrl,
  input  emr_pkg::lab_stat_t  stat
);
  import emr_pkg::*;

  localparam logic [MAX_CELLS:0] ONE_WIDE = 1;
  localparam logic [MAX_CELLS-1:0] ROW_MASK = MAX_CELLS'((ONE_WIDE << CELLS) - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
  localparam logic [IDX_W-1:0] JOIN_LAST = IDX_W'(CELLS - 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FORM,
    S_JOIN,
    S_DONE
  } state_t;

  state_t state;
  item_word_t cur;
  logic [IDX_W-1:0] idx;
  logic [MAX_CELLS-1:0] right;
  logic [MAX_CELLS-1:0] carried_down;
  logic [MAX_CELLS-1:0] join_ext;
  logic [MAX_CELLS-1:0] open_mask;
  logic merged;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    join_ext = {1'b0, cur.join_bits};
    ctrl.idx = idx;
    ctrl.carried = carried_down[idx] & ~cur.first_row;
    ctrl.join_take = cur.final_row | join_ext[idx];
    case (state)
      S_IDLE: ctrl.cmd = item_valid ? CMD_START : CMD_NONE;
      S_FORM: ctrl.cmd = CMD_FORM;
      S_JOIN: ctrl.cmd = CMD_JOIN;
      default: ctrl.cmd = CMD_NONE;
    endcase
    merged = (state == S_JOIN) && ctrl.join_take && stat.differ;
    open_mask = (stat.leader | cur.down_bits) & ROW_MASK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_valid <= 1'b0;
      carried_down <= '0;
      idx <= '0;
    end else begin
      if (row_valid && !row_stall && state != S_DONE) begin
        row_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            idx <= '0;
            right <= ROW_MASK;
            state <= S_FORM;
          end
        end
        S_FORM: begin
          if (idx == LAST_IDX) begin
            idx <= '0;
            state <= S_JOIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_JOIN: begin
          if (merged) begin
            right[idx] <= 1'b0;
          end
          if (idx == JOIN_LAST) begin
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!row_valid || !row_stall) begin
            row.right_walls <= right;
            row.bottom_walls <= cur.final_row ? ROW_MASK : (ROW_MASK & ~open_mask);
            row.maze_done <= cur.final_row;
            row_valid <= 1'b1;
            carried_down <= cur.final_row ? '0 : open_mask;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: dv/tb_eller_maze_row_generator.sv
// Self-checking testbench for the Eller maze row generator with a built-in row predictor.
`timescale 1ns / 1ps

module tb_eller_maze_row_generator;
  import emr_pkg::*;

  localparam int CELLS = ROW_CELLS_DEFAULT;
  localparam int ROW_LATENCY = 2 * CELLS + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 450;

  typedef logic [MAX_CELLS-1:0][5:0] lab_vec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  item_word_t item = '0;
  logic       row_valid;
  logic       row_stall = 1'b0;
  row_word_t  row;

  logic [4:0] cell_set [MAX_CELLS];
  bit         cell_carried [MAX_CELLS];
  row_word_t  pending_rows [$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_wait = 0;
  int idle_cycles = 0;
  int errors = 0;
  int items_sent = 0;
  int rows_checked = 0;
  int final_rows = 0;
  int mazes_sent = 0;

  eller_maze_row_generator #(
    .ROW_CELLS(CELLS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row       (row)
  );

  always #5 clk = ~clk;

  function automatic lab_vec_t leftmost_labels(lab_vec_t lab);
    lab_vec_t renamed;
    bit found;
    renamed = lab;
    for (int x = 0; x < CELLS; x++) begin
      found = 1'b0;
      for (int i = 0; i <= x; i++) begin
        if (!found && lab[i] == lab[x]) begin
          renamed[x] = 6'(i);
          found = 1'b1;
        end
      end
    end
    return renamed;
  endfunction

  // Advances the predicted row state by one word and returns the row it yields.
  function automatic row_word_t predict_row(item_word_t w);
    lab_vec_t lab;
    row_word_t r;
    logic [5:0] gone;
    logic [5:0] keep;
    lab = '0;
    r.right_walls = {MAX_CELLS{1'b1}} >> (MAX_CELLS - CELLS);
    r.bottom_walls = r.right_walls;
    r.maze_done = w.final_row;
    for (int x = 0; x < CELLS; x++) begin
      if (!w.first_row && cell_carried[x]) lab[x] = {1'b0, cell_set[x]};
      else lab[x] = 6'(32 + x);
    end
    lab = leftmost_labels(lab);
    for (int x = 0; x + 1 < CELLS; x++) begin
      if (lab[x] != lab[x+1] && (w.final_row || w.join_bits[x])) begin
        gone = lab[x+1];
        keep = lab[x];
        r.right_walls[x] = 1'b0;
        for (int i = 0; i < CELLS; i++) begin
          if (lab[i] == gone) lab[i] = keep;
        end
      end
    end
    lab = leftmost_labels(lab);
    for (int x = 0; x < MAX_CELLS; x++) cell_carried[x] = 1'b0;
    if (!w.final_row) begin
      for (int x = 0; x < CELLS; x++) begin
        if (lab[x] == 6'(x) || w.down_bits[x]) begin
          r.bottom_walls[x] = 1'b0;
          cell_carried[x] = 1'b1;
        end
      end
    end
    for (int x = 0; x < MAX_CELLS; x++) begin
      cell_set[x] = (x < CELLS) ? lab[x][4:0] : 5'(x);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_bits();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom & $urandom;
      2: return $urandom | $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_item(input logic [30:0] join_bits, input logic [31:0] down_bits,
                           input bit first_row, input bit final_row);
    item_word_t w;
    int gap;
    w.join_bits = join_bits;
    w.down_bits = down_bits;
    w.first_row = first_row;
    w.final_row = final_row;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    pending_rows.push_back(predict_row(w));
    items_sent++;
    if (first_row) mazes_sent++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (row_valid && !row_stall) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("row word with nothing pending", row.right_walls, '0);
        end else begin
          if (row.right_walls !== pending_rows[0].right_walls)
            report_mismatch("right_walls", row.right_walls, pending_rows[0].right_walls);
          if (row.bottom_walls !== pending_rows[0].bottom_walls)
            report_mismatch("bottom_walls", row.bottom_walls, pending_rows[0].bottom_walls);
          if (row.maze_done !== pending_rows[0].maze_done)
            report_mismatch("maze_done", 32'(row.maze_done), 32'(pending_rows[0].maze_done));
          if (pending_rows[0].maze_done) final_rows++;
          void'(pending_rows.pop_front());
          rows_checked++;
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
      end else if (row_valid && rx_wait > 0) begin
        rx_wait--;
      end
      row_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (row_valid && !row_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_no_first_row();
    for (int k = 0; k < 3; k++) send_item(31'(rand_bits()), rand_bits(), 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_item('1, '0, 1'b1, 1'b0);
    send_item('0, '1, 1'b0, 1'b0);
    send_item('1, '1, 1'b0, 1'b0);
    send_item('0, '0, 1'b0, 1'b0);
    send_item(31'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0);
    send_item(31'h2AAA_AAAA, 32'h5555_5555, 1'b0, 1'b0);
    send_item('0, '1, 1'b0, 1'b1);
  endtask

  task automatic test_final_rows();
    send_item(31'(rand_bits()), rand_bits(), 1'b1, 1'b0);
    send_item(31'(rand_bits()), rand_bits(), 1'b0, 1'b0);
    send_item('1, '1, 1'b0, 1'b1);
    send_item(31'(rand_bits()), rand_bits(), 1'b1, 1'b0);
    send_item(31'(rand_bits()), rand_bits(), 1'b0, 1'b1);
    send_item(31'(rand_bits()), rand_bits(), 1'b0, 1'b0);
    send_item(31'(rand_bits()), rand_bits(), 1'b0, 1'b0);
  endtask

  task automatic test_first_and_last();
    send_item('0, '1, 1'b1, 1'b1);
    send_item(31'(rand_bits()), rand_bits(), 1'b1, 1'b1);
    send_item('1, '0, 1'b0, 1'b0);
  endtask

  // Mostly complete mazes; some are cut short and some words carry random flags.
  task automatic test_random_mazes();
    int sent;
    int depth;
    int style;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      style = $urandom_range(0, 9);
      if (style == 0) begin
        send_item(31'($urandom), $urandom, 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        depth = $urandom_range(1, 12);
        for (int r = 0; r <= depth; r++) begin
          send_item(31'(rand_bits()), rand_bits(), r == 0, (r == depth) && (style != 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    for (int x = 0; x < MAX_CELLS; x++) begin
      cell_set[x] = 5'(x);
      cell_carried[x] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_no_first_row();
    test_field_extremes();
    test_final_rows();
    test_first_and_last();
    test_random_mazes();
    item_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (ROW_LATENCY + 10) @(posedge clk);
    $display("Sent %0d item words starting %0d mazes; checked %0d row words, %0d final.",
             items_sent, mazes_sent, rows_checked, final_rows);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
